### rtl/core/prq_pkg.sv
// Package for the priority ready queues: field widths, codes and defaults.
`default_nettype none
package prq_pkg;

  localparam int NUM_PRIORITIES_DEF = 8;
  localparam int QUEUE_DEPTH_DEF    = 8;
  localparam int NUM_TASKS_DEF      = 32;

  localparam int FUNC_W    = 1;
  localparam int PRIO_IN_W = 8;
  localparam int TASK_IN_W = 6;
  localparam int STATUS_W  = 3;
  localparam int TASK_W    = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_TASK = 3'd1,
    ST_BAD_PRIO = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

endpackage
`default_nettype wire

### rtl/core/prq_if.sv
// Channel interfaces for request items and result items.
`default_nettype none
interface prq_in_if
  import prq_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [PRIO_IN_W-1:0] prio;
  logic [TASK_IN_W-1:0] task_id;

  modport source (output valid, func, prio, task_id, input ready);
  modport sink   (input valid, func, prio, task_id, output ready);
endinterface

interface prq_out_if
  import prq_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                task_valid;
  logic [TASK_W-1:0]   out_task_id;

  modport source (output valid, status, task_valid, out_task_id, input ready);
  modport sink   (input valid, status, task_valid, out_task_id, output ready);
endinterface
`default_nettype wire

### rtl/core/prq_ram.sv
// Generic RAM with one write port and one registered read port.
`default_nettype none
module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### rtl/core/priority_ready_queues.sv
// Priority ready queues: one ring FIFO of task ids per priority level.
// Each item is a push or a pop on the queue of one priority and gives one
// result item, registered, in the cycle after it is accepted. One item is
// accepted every cycle; the only limit is the result register, so ready
// is low while a result waits and is not taken in that cycle. Task ids sit
// in one RAM of NUM_PRIORITIES*QUEUE_DEPTH entries, whose registered read
// port supplies the popped id; head, tail and full flag of each queue are
// flip-flops cleared by reset, so no clearing pass is needed.
`default_nettype none
module priority_ready_queues
  import prq_pkg::*;
#(
  parameter int NUM_PRIORITIES = NUM_PRIORITIES_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int NUM_TASKS      = NUM_TASKS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  prq_in_if.sink    in_i,
  prq_out_if.source out_o
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int PRIO_W = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
  localparam int SLOTS  = NUM_PRIORITIES * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(SLOTS);

  localparam logic [PRIO_IN_W:0] PrioLimit = (PRIO_IN_W+1)'(NUM_PRIORITIES);
  localparam logic [TASK_IN_W:0] TaskLimit = (TASK_IN_W+1)'(NUM_TASKS);
  localparam logic [PTR_W-1:0]   PtrLast   = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [ADDR_W-1:0]  DepthA    = ADDR_W'(QUEUE_DEPTH);

  logic [PTR_W-1:0] head_q [NUM_PRIORITIES];
  logic [PTR_W-1:0] tail_q [NUM_PRIORITIES];
  logic             full_q [NUM_PRIORITIES];

  logic              out_valid_q;
  status_e           status_q, status_d;
  logic              tvalid_q;
  logic [TASK_W-1:0] rdata;

  logic              accept;
  logic              prio_ok, task_ok, is_pop, not_empty;
  logic              push_en, pop_en;
  logic [PRIO_W-1:0] pidx;
  logic [PTR_W-1:0]  head_c, tail_c, head_inc, tail_inc;
  logic              full_c;
  logic [ADDR_W-1:0] waddr, raddr;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;

  assign pidx     = in_i.prio[PRIO_W-1:0];
  assign head_c   = head_q[pidx];
  assign tail_c   = tail_q[pidx];
  assign full_c   = full_q[pidx];
  assign head_inc = (head_c == PtrLast) ? '0 : head_c + PTR_W'(1);
  assign tail_inc = (tail_c == PtrLast) ? '0 : tail_c + PTR_W'(1);

  assign prio_ok   = {1'b0, in_i.prio} < PrioLimit;
  assign task_ok   = {1'b0, in_i.task_id} < TaskLimit;
  assign is_pop    = in_i.func == FUNC_POP;
  assign not_empty = (tail_c != head_c) || full_c;

  always_comb begin
    push_en  = 1'b0;
    pop_en   = 1'b0;
    status_d = ST_OK;
    priority if (!prio_ok) begin
      status_d = ST_BAD_PRIO;
    end else if (!is_pop) begin
      priority if (!task_ok) begin
        status_d = ST_BAD_TASK;
      end else if (full_c) begin
        status_d = ST_FULL;
      end else begin
        push_en = accept;
      end
    end else if (not_empty) begin
      pop_en = accept;
    end else begin
      status_d = ST_EMPTY;
    end
  end

  assign waddr = ADDR_W'(pidx) * DepthA + ADDR_W'(head_c);
  assign raddr = ADDR_W'(pidx) * DepthA + ADDR_W'(tail_c);

  prq_ram #(
    .WIDTH(TASK_W),
    .DEPTH(SLOTS)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (push_en),
    .waddr_i(waddr),
    .wdata_i(in_i.task_id[TASK_W-1:0]),
    .re_i   (pop_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PRIORITIES; p++) begin
        head_q[p] <= '0;
        tail_q[p] <= '0;
        full_q[p] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (push_en) begin
        head_q[pidx] <= head_inc;
        full_q[pidx] <= head_inc == tail_c;
      end
      if (pop_en) begin
        tail_q[pidx] <= tail_inc;
        full_q[pidx] <= 1'b0;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      tvalid_q <= pop_en;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.task_valid  = tvalid_q;
  assign out_o.out_task_id = tvalid_q ? rdata : '0;

  logic ptr_bad;
  always_comb begin
    ptr_bad = 1'b0;
    for (int p = 0; p < NUM_PRIORITIES; p++) begin
      ptr_bad = ptr_bad | (full_q[p] && (head_q[p] != tail_q[p]));
    end
  end

`ifndef ASSERT_OFF
  a_full_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ptr_bad)
    else $error("full queue with head and tail apart");

  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_en |=> out_o.valid && out_o.task_valid && out_o.status == ST_OK)
    else $error("pop did not return a task id");

  a_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.task_valid |-> out_o.status == ST_OK)
    else $error("task id returned with an error status");
`endif

endmodule
`default_nettype wire
